// File: rtl/ffdx_pkg.sv
// Shared constants and types for the fixed-frame deframer with XOR check.
package ffdx_pkg;

   localparam int PAYLOAD_BYTES = 64;

   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK   = 8'h55;

   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int POS_W = $clog2(PAYLOAD_BYTES + 5);

   localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LEN_L = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN_H = POS_W'(2);
   localparam logic [POS_W-1:0] POS_DATA  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CHECK = POS_W'(PAYLOAD_BYTES + 3);

   localparam logic [15:0] MAX_LEN = 16'(PAYLOAD_BYTES);

   // Frame verdict handed from the parser to the result streamer.
   typedef struct packed {
      logic             go;
      logic             reject;
      logic             no_data;
      logic [7:0]       ftype;
      logic [CNT_W-1:0] flen;
   } launch_type;

   // Payload buffer write port.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

endpackage

// File: rtl/ffdx_if.sv
// Request and response channel interfaces of the deframer.
interface ffdx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffdx_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] frame_type;
   logic [6:0] frame_length;
   logic [7:0] payload_byte;
   logic [5:0] byte_index;
   logic       last;

   modport source (output valid, output status, output frame_type, output frame_length,
                   output payload_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input status, input frame_type, input frame_length,
                   input payload_byte, input byte_index, input last, output ready);
endinterface

// File: rtl/ffdx_streamer.sv
// Payload buffer and result streamer: holds the frame payload, plays back results.
module ffdx_streamer
   import ffdx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  wr_type     wr,
   input  launch_type launch,
   output logic       busy,
   ffdx_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      SS_IDLE  = 3'b001,
      SS_FETCH = 3'b010,
      SS_SHOW  = 3'b100
   } sstate_type;

   sstate_type       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             reject_ff, reject_in;
   logic             no_data_ff, no_data_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [CNT_W-1:0] flen_ff, flen_in;
   logic [7:0]       rdata_ff;
   logic [7:0]       mem [PAYLOAD_BYTES];
   logic             is_last;
   logic             rd_en;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[idx_ff];
      end
   end

   assign rd_en   = (state_ff == SS_FETCH);
   assign is_last = no_data_ff || ((CNT_W'(idx_ff) + CNT_W'(1)) == flen_ff);
   assign busy    = (state_ff != SS_IDLE);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      reject_in  = reject_ff;
      no_data_in = no_data_ff;
      ftype_in   = ftype_ff;
      flen_in    = flen_ff;
      unique case (state_ff)
         SS_IDLE: begin
            if (launch.go) begin
               idx_in     = '0;
               reject_in  = launch.reject;
               no_data_in = launch.no_data;
               ftype_in   = launch.ftype;
               flen_in    = launch.flen;
               state_in   = launch.no_data ? SS_SHOW : SS_FETCH;
            end
         end
         SS_FETCH: begin
            state_in = SS_SHOW;
         end
         SS_SHOW: begin
            if (rsp.ready) begin
               if (is_last) begin
                  state_in = SS_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = SS_FETCH;
               end
            end
         end
         default: state_in = SS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff     <= idx_in;
      reject_ff  <= reject_in;
      no_data_ff <= no_data_in;
      ftype_ff   <= ftype_in;
      flen_ff    <= flen_in;
   end

   assign rsp.valid        = (state_ff == SS_SHOW);
   assign rsp.status       = reject_ff;
   assign rsp.frame_type   = ftype_ff;
   assign rsp.frame_length = 7'(flen_ff);
   assign rsp.payload_byte = no_data_ff ? 8'h00 : rdata_ff;
   assign rsp.byte_index   = no_data_ff ? 6'd0 : 6'(idx_ff);
   assign rsp.last         = is_last;

`ifndef SYNTHESIS
   // every fetch is followed by a shown result
   a_fetch_shows: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == SS_SHOW))
      else $error("fetch not followed by result");

   // the final beat of a frame frees the streamer
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last) |=> !busy)
      else $error("streamer still busy after last beat");

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.payload_byte)
         && $stable(rsp.byte_index) && $stable(rsp.last))
      else $error("stalled result beat changed");
`endif

endmodule

// File: rtl/fixed_frame_deframer_xor_check_top.sv
// Top level of the fixed-frame deframer with XOR checksum.
// Usage:
//   req carries one received byte per beat (rx_byte). Bytes are dropped until
//   the start marker 0xAA, then a fixed frame is collected: type, 16-bit
//   little-endian length, PAYLOAD_BYTES payload bytes, checksum, end byte.
//   rsp carries results. A good frame gives one beat per payload byte (or
//   one beat for a zero length), a bad frame one rejected beat; the final
//   beat of every frame has last set.
// Timing:
//   A byte is taken on every req beat up to the end byte. After the end byte
//   req.ready stays low while results play back: a buffer read, then the beat
//   on the registered read data, for each result beat.
//   The first beat follows the buffer read after the end byte (a zero-length
//   or rejected frame skips the read); req reopens once the streamer is idle again.
// Reset:
//   Synchronous, active high; the block returns to hunting for the start
//   marker. The payload buffer is not cleared; only entries written in the
//   current frame are ever read back.
// Stall:
//   A result beat holds until rsp.ready; no input is taken meanwhile.
module fixed_frame_deframer_xor_check_top
   import ffdx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ffdx_req_if.sink   req,
   ffdx_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_HUNT  = 3'b001,
      ST_BODY  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       chk_ff, chk_in;

   logic             beat;
   logic [POS_W-1:0] data_pos;
   logic             bad;
   logic             busy;
   launch_type       launch;
   wr_type           wr;

   assign req.ready = (state_ff != ST_DRAIN);
   assign beat      = req.valid && req.ready;
   assign data_pos  = pos_ff - POS_DATA;

   // frame verdict, valid when the end byte is on the bus
   assign bad = (req.rx_byte != END_MARK) || (len_ff > MAX_LEN) || (chk_ff != xor_ff);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      xor_in   = xor_ff;
      chk_in   = chk_ff;
      wr       = '{en: 1'b0, addr: IDX_W'(data_pos), data: req.rx_byte};
      launch   = '{go: 1'b0, reject: bad, no_data: bad || (len_ff == 16'd0),
                   ftype: bad ? 8'h00 : type_ff,
                   flen: bad ? CNT_W'(0) : CNT_W'(len_ff)};
      unique case (state_ff)
         ST_HUNT: begin
            if (beat && (req.rx_byte == START_MARK)) begin
               pos_in   = '0;
               xor_in   = 8'h00;
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (beat) begin
               pos_in = pos_ff + POS_W'(1);
               if (pos_ff == POS_TYPE) begin
                  type_in = req.rx_byte;
                  xor_in  = req.rx_byte;
               end else if (pos_ff == POS_LEN_L) begin
                  len_in = {len_ff[15:8], req.rx_byte};
                  xor_in = xor_ff ^ req.rx_byte;
               end else if (pos_ff == POS_LEN_H) begin
                  len_in = {req.rx_byte, len_ff[7:0]};
                  xor_in = xor_ff ^ req.rx_byte;
               end else if (pos_ff < POS_CHECK) begin
                  // payload byte: store it; only the first len bytes count
                  wr.en = 1'b1;
                  if (16'(data_pos) < len_ff) begin
                     xor_in = xor_ff ^ req.rx_byte;
                  end
               end else if (pos_ff == POS_CHECK) begin
                  chk_in = req.rx_byte;
               end else begin
                  // end byte: judge and hand over to the streamer
                  launch.go = 1'b1;
                  pos_in    = '0;
                  state_in  = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_HUNT;
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
      type_ff <= type_in;
      len_ff  <= len_in;
      xor_ff  <= xor_in;
      chk_ff  <= chk_in;
   end

   ffdx_streamer u_streamer (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .launch (launch),
      .busy   (busy),
      .rsp    (rsp)
   );

`ifndef SYNTHESIS
   // results only appear while input is held off
   a_rsp_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (state_ff == ST_DRAIN))
      else $error("result beat outside drain");

   // a verdict is only issued from the frame body
   a_launch_body: assert property (@(posedge clock) disable iff (reset)
      launch.go |-> (state_ff == ST_BODY) && beat)
      else $error("launch outside frame body");

   // the streamer picks up every verdict
   a_launch_taken: assert property (@(posedge clock) disable iff (reset)
      launch.go |=> busy)
      else $error("streamer missed a frame verdict");
`endif

endmodule

// File: tb/tb_top.sv
// Testbench for the fixed-frame deframer: directed frames, random frames, beat-level checking.
`timescale 1ns / 100ps

module tb_top;
   import ffdx_pkg::*;

   // Cycles without any beat on either channel before the run is called hung.
   // The long receiver hold-off below is the largest legal quiet stretch.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Quiet cycles after the last expected beat before the verdict.
   localparam int SETTLE_CYCLES = 20;
   localparam int FRAMES_PER_PHASE = 34;

   // One result beat as seen on rsp.
   typedef struct packed {
      logic       status;
      logic [7:0] frame_type;
      logic [6:0] frame_length;
      logic [7:0] payload_byte;
      logic [5:0] byte_index;
      logic       last;
   } beat_type;

   // Per directed frame: use the typed-in beat instead of the predictor.
   typedef struct {
      logic     typed;
      beat_type beat;
   } override_type;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_MARKS, FILL_RAND} fill_type;

   // How a directed row is checked: by the frame predictor, or by a
   // typed-in single beat (nack, or accepted with zero length).
   typedef enum {ROW_MODEL, ROW_NACK, ROW_EMPTY} row_check_type;

   typedef struct {
      int            noise;
      logic [7:0]    ftype;
      logic [15:0]   flen;
      fill_type      fill;
      logic          bad_check;
      logic [7:0]    end_byte;
      row_check_type check;
   } frame_row_type;

   logic clock;
   logic reset;

   ffdx_req_if req_ch ();
   ffdx_rsp_if rsp_ch ();

   fixed_frame_deframer_xor_check_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // ---------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Frame predictor: own copy of the deframer state
   // ---------------------------------------------------------------
   logic       pr_hunting;
   int         pr_pos;
   logic [7:0] pr_type;
   logic [15:0] pr_len;
   logic [7:0] pr_xor;
   logic [7:0] pr_check;
   logic [7:0] pr_payload [PAYLOAD_BYTES];

   beat_type expected_beats [$];

   // One entry per directed frame, taken in order at its end byte; a typed
   // entry replaces the predictor's output, the predictor state still advances.
   override_type row_overrides [$];

   int mismatches;

   task automatic deframe_byte(input logic [7:0] b);
      int           pos;
      logic         frame_ok;
      logic         use_typed;
      beat_type     r;
      override_type ov;
      if (pr_hunting) begin
         // Anything but the start marker is dropped while hunting.
         if (b == START_MARK) begin
            pr_hunting = 1'b0;
            pr_pos     = 0;
            pr_xor     = 8'h00;
         end
      end else begin
         pos    = pr_pos;
         pr_pos = pos + 1;
         if (pos == 0) begin
            pr_type = b;
            pr_xor  = b;
         end else if (pos == 1) begin
            pr_len[7:0] = b;
            pr_xor      = pr_xor ^ b;
         end else if (pos == 2) begin
            pr_len[15:8] = b;
            pr_xor       = pr_xor ^ b;
         end else if (pos < 3 + PAYLOAD_BYTES) begin
            // Marker values in here are plain data.
            pr_payload[pos-3] = b;
            if ((pos - 3) < int'(pr_len))
               pr_xor = pr_xor ^ b;
         end else if (pos == 3 + PAYLOAD_BYTES) begin
            pr_check = b;
         end else begin
            // End byte: judge the frame, then hunt again.
            pr_hunting = 1'b1;
            pr_pos     = 0;
            frame_ok   = (b == END_MARK) && (pr_len <= MAX_LEN) && (pr_check == pr_xor);
            use_typed  = 1'b0;
            if (row_overrides.size() != 0) begin
               ov        = row_overrides.pop_front();
               use_typed = ov.typed;
            end
            if (use_typed) begin
               expected_beats.push_back(ov.beat);
            end else if (!frame_ok) begin
               expected_beats.push_back('{1'b1, 8'h00, 7'd0, 8'h00, 6'd0, 1'b1});
            end else if (pr_len == 16'd0) begin
               expected_beats.push_back('{1'b0, pr_type, 7'd0, 8'h00, 6'd0, 1'b1});
            end else begin
               for (int k = 0; k < int'(pr_len); k++) begin
                  r.status       = 1'b0;
                  r.frame_type   = pr_type;
                  r.frame_length = pr_len[6:0];
                  r.payload_byte = pr_payload[k];
                  r.byte_index   = 6'(k);
                  r.last         = (k == int'(pr_len) - 1);
                  expected_beats.push_back(r);
               end
            end
         end
      end
   endtask

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   task automatic check_beat();
      beat_type e;
      if (expected_beats.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected beat, expected none, actual %0h", $time,
                  {rsp_ch.status, rsp_ch.frame_type, rsp_ch.frame_length,
                   rsp_ch.payload_byte, rsp_ch.byte_index, rsp_ch.last});
      end else begin
         e = expected_beats.pop_front();
         check_field("status",       e.status,       rsp_ch.status);
         check_field("frame_type",   e.frame_type,   rsp_ch.frame_type);
         check_field("frame_length", e.frame_length, rsp_ch.frame_length);
         check_field("payload_byte", e.payload_byte, rsp_ch.payload_byte);
         check_field("byte_index",   e.byte_index,   rsp_ch.byte_index);
         check_field("last",         e.last,         rsp_ch.last);
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Prediction comes
   // first so a beat on the same edge would already find its expectation.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            deframe_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            check_beat();
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: quiet cycles on both channels
   // ---------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver: random ready, plus a long hold-off on request. The hold-off
   // is counted here so the sender keeps offering bytes meanwhile.
   // ---------------------------------------------------------------
   int   rsp_idle_pct;
   logic hold_start;

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   int         req_idle_pct;
   logic [7:0] frame_payload [PAYLOAD_BYTES];

   // Drives one byte from the falling edge and returns at the rising edge
   // that takes it. valid is left high; the next call decides whether to idle.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Line noise: anything but the start marker.
   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         do
            b = 8'($urandom_range(255));
         while (b == START_MARK);
         send_byte(b);
      end
   endtask

   function automatic void fill_payload(input fill_type fill);
      int r;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         case (fill)
            FILL_ZERO:  frame_payload[i] = 8'h00;
            FILL_ONES:  frame_payload[i] = 8'hFF;
            FILL_COUNT: frame_payload[i] = 8'(i + 1);
            FILL_MARKS: frame_payload[i] = i[0] ? END_MARK : START_MARK;
            default: begin
               // Random, with marker values salted in.
               r = $urandom_range(9);
               if (r == 0)
                  frame_payload[i] = START_MARK;
               else if (r == 1)
                  frame_payload[i] = END_MARK;
               else
                  frame_payload[i] = 8'($urandom_range(255));
            end
         endcase
      end
   endfunction

   // Whole fixed-size frame from frame_payload; the checksum is computed
   // here and optionally spoiled.
   task automatic send_frame(input int noise, input logic [7:0] ftype, input logic [15:0] flen,
                             input logic bad_check, input logic [7:0] end_byte);
      logic [7:0] chk;
      send_noise(noise);
      send_byte(START_MARK);
      send_byte(ftype);
      send_byte(flen[7:0]);
      send_byte(flen[15:8]);
      chk = ftype ^ flen[7:0] ^ flen[15:8];
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if (i < int'(flen))
            chk = chk ^ frame_payload[i];
         send_byte(frame_payload[i]);
      end
      if (bad_check)
         chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk);
      send_byte(end_byte);
   endtask

   function automatic logic [15:0] pick_good_length();
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return 16'd0;
      else if (r == 1)
         return 16'(PAYLOAD_BYTES);
      else if (r == 2)
         return 16'd1;
      else
         return 16'($urandom_range(2, PAYLOAD_BYTES - 1));
   endfunction

   // Mostly well-formed frames with random content; the rest is broken
   // frames and bare noise.
   task automatic send_random_frame();
      int         pick;
      int         noise;
      logic [7:0] ftype;
      logic [15:0] flen;
      logic       bad_check;
      logic [7:0] end_byte;
      pick      = $urandom_range(99);
      noise     = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
      ftype     = 8'($urandom_range(255));
      if ($urandom_range(7) == 0)
         ftype = ftype[0] ? START_MARK : END_MARK;
      flen      = pick_good_length();
      bad_check = 1'b0;
      end_byte  = END_MARK;
      if (pick >= 95) begin
         send_noise($urandom_range(1, 8));
      end else begin
         if (pick >= 88) begin
            // Oversize length, checksum left correct.
            if ($urandom_range(1))
               flen = 16'($urandom_range(PAYLOAD_BYTES + 1, 255));
            else
               flen = {8'($urandom_range(1, 255)), 8'($urandom_range(255))};
         end else if (pick >= 80) begin
            do
               end_byte = 8'($urandom_range(255));
            while (end_byte == END_MARK);
         end else if (pick >= 70) begin
            bad_check = 1'b1;
         end
         fill_payload(FILL_RAND);
         send_frame(noise, ftype, flen, bad_check, end_byte);
      end
   endtask

   // Sender pause: drop valid, let every expected beat come out, then the
   // block settle.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Directed frames
   // ---------------------------------------------------------------
   frame_row_type directed_rows [15];

   initial begin
      directed_rows = '{
         // noise, type, length, fill, bad chk, end byte, check
         '{3, 8'h00, 16'd0,      FILL_ZERO,  1'b0, 8'h55, ROW_EMPTY},
         '{0, 8'hFF, 16'd0,      FILL_ONES,  1'b0, 8'h55, ROW_EMPTY},
         '{0, 8'h01, 16'd1,      FILL_COUNT, 1'b0, 8'h55, ROW_MODEL},
         '{1, 8'hAA, 16'd64,     FILL_MARKS, 1'b0, 8'h55, ROW_MODEL},
         '{0, 8'h55, 16'd63,     FILL_ONES,  1'b0, 8'h55, ROW_MODEL},
         '{0, 8'h00, 16'd64,     FILL_ZERO,  1'b0, 8'h55, ROW_MODEL},
         '{0, 8'hFF, 16'd64,     FILL_ONES,  1'b0, 8'h55, ROW_MODEL},
         '{2, 8'h12, 16'd65,     FILL_COUNT, 1'b0, 8'h55, ROW_NACK},
         '{0, 8'h34, 16'hFFFF,   FILL_ONES,  1'b0, 8'h55, ROW_NACK},
         '{0, 8'h56, 16'h0100,   FILL_ZERO,  1'b0, 8'h55, ROW_NACK},
         '{0, 8'h78, 16'd10,     FILL_RAND,  1'b1, 8'h55, ROW_NACK},
         '{0, 8'h9A, 16'd10,     FILL_RAND,  1'b0, 8'hAA, ROW_NACK},
         '{0, 8'hBC, 16'd10,     FILL_RAND,  1'b0, 8'h00, ROW_NACK},
         '{5, 8'hDE, 16'd32,     FILL_RAND,  1'b0, 8'hFF, ROW_NACK},
         '{0, 8'h5A, 16'd2,      FILL_MARKS, 1'b0, 8'h55, ROW_MODEL}
      };
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      override_type ov;
      reset          = 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      hold_start     = 1'b0;
      mismatches     = 0;
      pr_hunting     = 1'b1;
      pr_pos         = 0;
      pr_type        = 8'h00;
      pr_len         = 16'h0000;
      pr_xor         = 8'h00;
      pr_check       = 8'h00;
      req_idle_pct   = 23;
      rsp_idle_pct   = 61;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of type and length, marker values as data,
      // oversize length, bad checksum, bad end byte.
      foreach (directed_rows[i]) begin
         fill_payload(directed_rows[i].fill);
         ov.typed = 1'b0;
         ov.beat  = '0;
         if (directed_rows[i].check == ROW_NACK) begin
            ov.typed = 1'b1;
            ov.beat  = '{1'b1, 8'h00, 7'd0, 8'h00, 6'd0, 1'b1};
         end else if (directed_rows[i].check == ROW_EMPTY) begin
            ov.typed = 1'b1;
            ov.beat  = '{1'b0, directed_rows[i].ftype, 7'd0, 8'h00, 6'd0, 1'b1};
         end
         row_overrides.push_back(ov);
         send_frame(directed_rows[i].noise, directed_rows[i].ftype, directed_rows[i].flen,
                    directed_rows[i].bad_check, directed_rows[i].end_byte);
      end
      drain_results();

      // Random: three idling phases, each ending with a full drain.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 23;
               rsp_idle_pct = 61;
            end
            1: begin
               req_idle_pct = 61;
               rsp_idle_pct = 23;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
            if (phase == 0 && f == 4) begin
               // Full-length frame, then the receiver stalls long while the
               // sender keeps offering the next frame's bytes.
               fill_payload(FILL_RAND);
               hold_start = 1'b1;
               send_frame(0, 8'($urandom_range(255)), 16'(PAYLOAD_BYTES), 1'b0, END_MARK);
            end else begin
               send_random_frame();
            end
         end
         drain_results();
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      drain_results();

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/ffdx_pkg.sv
rtl/ffdx_if.sv
rtl/ffdx_streamer.sv
rtl/fixed_frame_deframer_xor_check_top.sv
tb/tb_top.sv
